// ----- hdl/layer_ring_isolation_sum_defines.svh -----
// assertion macros for the layer ring isolation sum block
// used by the controller and the top level
`ifndef LAYER_RING_ISOLATION_SUM_DEFINES_SVH
`define LAYER_RING_ISOLATION_SUM_DEFINES_SVH
`ifndef SYNTHESIS
`define LRIS_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error("label failed");
`define LRIS_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("label failed");
`else
`define LRIS_ASSERT(label, clk, rst, prop)
`define LRIS_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// ----- hdl/lris_pkg.sv -----
// shared types and constants of the layer ring isolation sum block
// no dependencies
package lris_pkg;
  localparam int NUM_LAYERS_DEF = 64;
  localparam int MAX_RINGS_DEF  = 16;
  localparam int RING_SLOTS     = 16;
  localparam int RING_W         = 4;
  localparam int PI_Q           = 804;
  localparam int TWO_PI_Q       = 1608;

  localparam logic [1:0] REQ_BEGIN = 2'd0;
  localparam logic [1:0] REQ_HIT   = 2'd1;
  localparam logic [1:0] REQ_END   = 2'd2;

  localparam logic [1:0] REG_MAX_RADIUS = 2'd0;
  localparam logic [1:0] REG_MIN_RADIUS = 2'd1;
  localparam logic [1:0] REG_RING_COUNT = 2'd2;

  // controller to datapath commands
  typedef struct packed {
    logic begin_load;   // latch photon, clear sums
    logic clear_sums;   // ring count written
    logic hit_calc;     // register distance and ring of hit
    logic hit_commit;   // read-modify-write the ring sum
    logic div_start;    // load divider for ring div_ring
    logic div_step;     // one quotient bit
    logic [RING_W-1:0] div_ring;
  } lris_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic div_done;
    logic [RING_W:0] rings;  // rings in use, 1..16
  } lris_stat_t;
endpackage

// ----- hdl/lris_stream_if.sv -----
// valid/ready channel interfaces of the layer ring isolation sum block
// depends on nothing
interface lris_in_if;
  logic valid;
  logic ready;
  logic [1:0] req_type;
  logic signed [10:0] photon_eta;
  logic signed [10:0] photon_phi;
  logic [19:0] photon_energy;
  logic signed [10:0] hit_eta;
  logic signed [10:0] hit_phi;
  logic [6:0] hit_layer;
  logic [15:0] hit_energy;
  logic hit_in_cluster;
  modport source (output valid, req_type, photon_eta, photon_phi, photon_energy, hit_eta,
                  hit_phi, hit_layer, hit_energy, hit_in_cluster, input ready);
  modport sink (input valid, req_type, photon_eta, photon_phi, photon_energy, hit_eta,
                hit_phi, hit_layer, hit_energy, hit_in_cluster, output ready);
endinterface

interface lris_out_if;
  logic valid;
  logic ready;
  logic [3:0] ring_index;
  logic [23:0] iso_ratio;
  logic zero_energy;
  logic last;
  modport source (output valid, ring_index, iso_ratio, zero_energy, last, input ready);
  modport sink (input valid, ring_index, iso_ratio, zero_energy, last, output ready);
endinterface

interface lris_cfg_if;
  logic valid;
  logic ready;
  logic [1:0] index;
  logic [9:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- hdl/lris_datapath.sv -----
// datapath: config registers, photon latch, ring sums, veto logic, serial divider
// depends on lris_pkg
module lris_datapath #(
  parameter int NUM_LAYERS = lris_pkg::NUM_LAYERS_DEF,
  parameter int MAX_RINGS  = lris_pkg::MAX_RINGS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [9:0] cfg_data,
  input  logic [1:0] req_type,
  input  logic signed [10:0] photon_eta,
  input  logic signed [10:0] photon_phi,
  input  logic [19:0] photon_energy,
  input  logic signed [10:0] hit_eta,
  input  logic signed [10:0] hit_phi,
  input  logic [6:0] hit_layer,
  input  logic [15:0] hit_energy,
  input  logic hit_in_cluster,
  input  lris_pkg::lris_cmd_t cmd,
  output lris_pkg::lris_stat_t stat,
  output logic [23:0] ratio,
  output logic zero_energy
);
  localparam int RMAX = (MAX_RINGS < lris_pkg::RING_SLOTS) ? MAX_RINGS : lris_pkg::RING_SLOTS;
  localparam int RCAP = (RMAX < NUM_LAYERS) ? RMAX : NUM_LAYERS;

  logic [9:0] max_radius, min_radius;
  logic [4:0] ring_count;
  logic signed [10:0] ph_eta, ph_phi;
  logic [19:0] ph_energy;
  logic [31:0] ring_sums [lris_pkg::RING_SLOTS];
  logic [lris_pkg::RING_SLOTS-1:0] sum_valid;

  // rings in use
  logic [4:0] rings;
  always_comb begin
    rings = ring_count;
    if (rings == 5'd0) rings = 5'd1;
    if (32'(rings) > RCAP) rings = 5'(RCAP);
  end
  assign stat.rings = rings;

  // layers per ring for every ring count, built at elaboration
  function automatic logic [16:0][6:0] lpr_table();
    logic [16:0][6:0] t;
    int q;
    int rest;
    begin
      t = '0;
      for (int r = 1; r <= 16; r++) begin
        q = 0;
        rest = NUM_LAYERS;
        while (rest >= r) begin
          rest = rest - r;
          q = q + 1;
        end
        if (q < 1) q = 1;
        t[r] = 7'(q);
      end
      t[0] = t[1];
      return t;
    end
  endfunction
  localparam logic [16:0][6:0] LPR_TAB = lpr_table();

  logic [6:0] layers_per_ring;
  assign layers_per_ring = LPR_TAB[rings];

  always_ff @(posedge clk) begin
    if (rst) begin
      max_radius <= 10'd38;
      min_radius <= 10'd0;
      ring_count <= 5'd5;
      ph_eta <= '0;
      ph_phi <= '0;
      ph_energy <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          lris_pkg::REG_MAX_RADIUS: max_radius <= cfg_data;
          lris_pkg::REG_MIN_RADIUS: min_radius <= cfg_data;
          lris_pkg::REG_RING_COUNT: ring_count <= cfg_data[4:0];
          default: ;
        endcase
      end
      if (cmd.begin_load) begin
        ph_eta <= photon_eta;
        ph_phi <= photon_phi;
        ph_energy <= photon_energy;
      end
    end
  end

  // stage one of a hit: distance, veto, ring
  logic signed [11:0] deta;
  logic signed [12:0] dphi;
  logic [22:0] d2;
  logic [19:0] maxr2, minr2;
  logic [6:0] lm1;
  logic [6:0] ring_raw;
  logic [3:0] ring_sel;
  logic keep;
  always_comb begin
    deta = 12'(hit_eta) - 12'(ph_eta);
    dphi = 13'(hit_phi) - 13'(ph_phi);
    if (dphi > 13'sd804) dphi = dphi - 13'sd1608;
    else if (dphi < -13'sd804) dphi = dphi + 13'sd1608;
    d2 = 23'(22'(deta * deta)) + 23'(22'(dphi * dphi));
    maxr2 = max_radius * max_radius;
    minr2 = min_radius * min_radius;
    lm1 = hit_layer - 7'd1;
    // quotient by threshold compare, thresholds rise with k
    ring_raw = 7'd0;
    for (int k = 1; k < 16; k++) begin
      if ({4'd0, lm1} >= 11'(k) * {4'd0, layers_per_ring}) ring_raw = 7'(k);
    end
    if (hit_layer == 7'd0) ring_raw = 7'd0;
    if (ring_raw > 7'(rings - 5'd1)) ring_raw = 7'(rings - 5'd1);
    ring_sel = ring_raw[3:0];
    keep = !hit_in_cluster && (32'(hit_layer) < NUM_LAYERS) &&
           (23'(maxr2) >= d2) && (d2 >= 23'(minr2));
  end

  logic h_keep;
  logic [3:0] h_ring;
  logic [15:0] h_energy;
  always_ff @(posedge clk) begin
    if (cmd.hit_calc) begin
      h_keep <= keep && (req_type == lris_pkg::REQ_HIT);
      h_ring <= ring_sel;
      h_energy <= hit_energy;
    end
  end

  logic [31:0] cur_sum;
  logic [32:0] add_sum;
  assign cur_sum = sum_valid[h_ring] ? ring_sums[h_ring] : 32'd0;
  assign add_sum = {1'b0, cur_sum} + {17'd0, h_energy};

  always_ff @(posedge clk) begin
    if (rst || cmd.begin_load || cmd.clear_sums) begin
      sum_valid <= '0;
    end else if (cmd.hit_commit && h_keep) begin
      sum_valid[h_ring] <= 1'b1;
    end
  end
  always_ff @(posedge clk) begin
    if (cmd.hit_commit && h_keep) begin
      ring_sums[h_ring] <= add_sum[32] ? 32'hFFFF_FFFF : add_sum[31:0];
    end
  end

  // restoring divider, 48 bit dividend, one quotient bit a step
  logic [47:0] dividend;
  logic [20:0] rem;
  logic [5:0] cnt;
  logic [20:0] trial;
  logic [20:0] rem_sh;
  assign rem_sh = {rem[19:0], dividend[47]};
  assign trial = rem_sh - {1'b0, ph_energy};
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dividend <= {(sum_valid[cmd.div_ring] ? ring_sums[cmd.div_ring] : 32'd0), 16'd0};
      rem <= '0;
      cnt <= 6'd48;
    end else if (cmd.div_step && cnt != 6'd0) begin
      if (!trial[20]) begin
        rem <= trial;
        dividend <= {dividend[46:0], 1'b1};
      end else begin
        rem <= rem_sh;
        dividend <= {dividend[46:0], 1'b0};
      end
      cnt <= cnt - 6'd1;
    end
  end
  assign stat.div_done = (cnt == 6'd0);
  assign zero_energy = (ph_energy == 20'd0);
  assign ratio = (zero_energy || dividend[47:24] != 24'd0) ? 24'hFF_FFFF : dividend[23:0];
endmodule

// ----- hdl/lris_ctrl.sv -----
// controller: request decode, hit sequencing, ring emit loop with divider
// depends on lris_pkg and the assertion macros
`include "layer_ring_isolation_sum_defines.svh"
module lris_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [1:0] req_type,
  input  logic cfg_we,
  input  logic [1:0] cfg_index,
  output logic out_valid,
  input  logic out_ready,
  output logic [3:0] out_ring,
  output logic out_last,
  output lris_pkg::lris_cmd_t cmd,
  input  lris_pkg::lris_stat_t stat
);
  typedef enum logic [2:0] {IDLE, HIT, DIV_START, DIV_RUN, EMIT} state_t;
  state_t state;
  logic [3:0] ring;
  logic acc;

  assign in_ready = (state == IDLE);
  assign acc = in_valid && in_ready;
  assign out_valid = (state == EMIT);
  assign out_ring = ring;
  assign out_last = (5'(ring) + 5'd1 == stat.rings);

  always_comb begin
    cmd = '0;
    cmd.begin_load = acc && req_type == lris_pkg::REQ_BEGIN;
    cmd.clear_sums = cfg_we && cfg_index == lris_pkg::REG_RING_COUNT;
    cmd.hit_calc = acc;
    cmd.hit_commit = (state == HIT);
    cmd.div_start = (state == DIV_START);
    cmd.div_step = (state == DIV_RUN);
    cmd.div_ring = ring;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      ring <= '0;
    end else begin
      case (state)
        IDLE: begin
          if (acc && req_type == lris_pkg::REQ_HIT) state <= HIT;
          else if (acc && req_type == lris_pkg::REQ_END) begin
            ring <= '0;
            state <= DIV_START;
          end
        end
        HIT: state <= IDLE;
        DIV_START: state <= DIV_RUN;
        DIV_RUN: if (stat.div_done) state <= EMIT;
        EMIT: begin
          if (out_ready) begin
            if (out_last) state <= IDLE;
            else begin
              ring <= ring + 4'd1;
              state <= DIV_START;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  `LRIS_ASSERT(a_ready_idle, clk, rst, in_ready |-> !out_valid)
  `LRIS_ASSERT(a_hit_one, clk, rst, (state == HIT) |=> (state == IDLE))
  `LRIS_ASSERT(a_ring_range, clk, rst, out_valid |-> (5'(ring) < stat.rings))
  `LRIS_ASSERT(a_emit_hold, clk, rst, (out_valid && !out_ready) |=> $stable(ring) && out_valid)
endmodule

// ----- hdl/layer_ring_isolation_sum.sv -----
// top level of the layer ring isolation sum block
// depends on lris_pkg, the channel interfaces, lris_ctrl and lris_datapath
//
// Sums hit energies in an eta-phi annulus around a latched photon, per ring of
// depth layers. A hit transfer does distance and ring decode, then the
// read-modify-write of the ring sum. An end transfer emits one result per ring
// in use; each ring passes through the shared restoring divider (one quotient
// bit per cycle over a 48 bit dividend) and then the output transfer. New input
// is taken only while the controller is idle. Configuration writes are accepted
// at any time; a ring count write clears the ring sums.
`include "layer_ring_isolation_sum_defines.svh"
module layer_ring_isolation_sum #(
  parameter int NUM_LAYERS = lris_pkg::NUM_LAYERS_DEF,
  parameter int MAX_RINGS  = lris_pkg::MAX_RINGS_DEF
) (
  input logic clk,
  input logic rst,
  lris_in_if.sink   in_ch,
  lris_out_if.source out_ch,
  lris_cfg_if.sink  cfg
);
  lris_pkg::lris_cmd_t cmd;
  lris_pkg::lris_stat_t stat;
  logic cfg_we;

  // config is always ready
  assign cfg.ready = 1'b1;
  assign cfg_we = cfg.valid;

  lris_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .req_type(in_ch.req_type),
    .cfg_we(cfg_we), .cfg_index(cfg.index),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_ring(out_ch.ring_index), .out_last(out_ch.last),
    .cmd(cmd), .stat(stat)
  );

  lris_datapath #(.NUM_LAYERS(NUM_LAYERS), .MAX_RINGS(MAX_RINGS)) u_dp (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg.index), .cfg_data(cfg.data),
    .req_type(in_ch.req_type),
    .photon_eta(in_ch.photon_eta), .photon_phi(in_ch.photon_phi),
    .photon_energy(in_ch.photon_energy),
    .hit_eta(in_ch.hit_eta), .hit_phi(in_ch.hit_phi), .hit_layer(in_ch.hit_layer),
    .hit_energy(in_ch.hit_energy), .hit_in_cluster(in_ch.hit_in_cluster),
    .cmd(cmd), .stat(stat),
    .ratio(out_ch.iso_ratio), .zero_energy(out_ch.zero_energy)
  );

  `LRIS_ASSERT(a_zero_sat, clk, rst, (out_ch.valid && out_ch.zero_energy) |-> (out_ch.iso_ratio == 24'hFFFFFF))
  `LRIS_ASSERT(a_no_in_while_out, clk, rst, out_ch.valid |-> !in_ch.ready)
  `LRIS_ASSERT_ALWAYS(a_cfg_ready, clk, cfg.ready)
endmodule
